/* hdl/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants of the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Quaternion registers are Q2.14
  localparam int QUAT_WIDTH      = 16;
  localparam int QUAT_FRAC_BITS  = 14;
  localparam int PROD_WIDTH      = 2 * QUAT_WIDTH;
  localparam int RAW_FRAC_BITS   = 2 * QUAT_FRAC_BITS;
  localparam int RAW_WIDTH       = 36;
  localparam int NUM_COEFFS      = 9;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QUAT_FRAC_BITS;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_FOUR  = 2'd0;  // w passed through
  localparam mode_t MODE_THREE = 2'd1;  // w forced to 1.0
  localparam mode_t MODE_TWO   = 2'd2;  // z taken as zero, w forced to 1.0

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_QUAT_X = 3'd0;
  localparam cfg_index_t REG_QUAT_Y = 3'd1;
  localparam cfg_index_t REG_QUAT_Z = 3'd2;
  localparam cfg_index_t REG_QUAT_W = 3'd3;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

/* hdl/quaternion_vector_rotator_core.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotator_core
// Rotates a stream of fixed-point vectors by a configured quaternion.
// ----------------------------------------------------------------------------
// Takes one vector per clock while in_stall is low and passes it through
// a multiply stage (nine vector x coefficient products), a sum stage
// (three row sums) and a round/saturate stage whose register holds the item
// for the output channel. Stalls on the output back up through the stages
// without losing or repeating items. A quaternion register write starts a
// coefficient recompute (products, then sum/round/clip); during it and
// during the write cycle itself cfg_ready or in_stall hold off new work, so
// the first vector after a write already sees the new rotation.
module quaternion_vector_rotator_core
  import qvr_pkg::*;
#(
  parameter int VECTOR_WIDTH    = 32,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic signed [VECTOR_WIDTH-1:0] in_vec_x,
  input  logic signed [VECTOR_WIDTH-1:0] in_vec_y,
  input  logic signed [VECTOR_WIDTH-1:0] in_vec_z,
  input  logic signed [VECTOR_WIDTH-1:0] in_vec_w,
  input  logic                           in_last_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VECTOR_WIDTH-1:0] out_x,
  output logic signed [VECTOR_WIDTH-1:0] out_y,
  output logic signed [VECTOR_WIDTH-1:0] out_z,
  output logic signed [VECTOR_WIDTH-1:0] out_w,
  output logic                           out_last_out,
  output logic                           out_saturated,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [QUAT_WIDTH-1:0]          cfg_data
);

  localparam int CW = COEFF_FRAC_BITS + 4;
  localparam int PW = VECTOR_WIDTH + CW;
  localparam int SW = PW + 2;

  logic [NUM_COEFFS-1:0][CW-1:0] coeff;
  logic                          coeff_busy;
  logic                          s1_up_valid, s1_up_ready;
  logic                          s2_up_ready, s3_up_ready;
  stage_ctl_t                    s1_ctl, s2_ctl, s3_ctl;
  logic [NUM_COEFFS-1:0][PW-1:0] s1_prod;
  logic [VECTOR_WIDTH-1:0]       s1_w, s2_w, s3_w;
  logic [2:0][SW-1:0]            s2_sum;
  logic [2:0][VECTOR_WIDTH-1:0]  s3_res;
  logic                          s3_sat;

  qvr_coeff_unit #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_coeff (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coeff    (coeff),
    .busy     (coeff_busy)
  );

  // no item enters while the coefficients are being written or rebuilt
  assign s1_up_valid = in_valid && !coeff_busy && !cfg_valid;
  assign in_stall    = !s1_up_ready || coeff_busy || cfg_valid;

  qvr_mult_stage #(
    .VECTOR_WIDTH   (VECTOR_WIDTH),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_up_valid),
    .up_ready  (s1_up_ready),
    .mode      (in_mode),
    .vec_x     (in_vec_x),
    .vec_y     (in_vec_y),
    .vec_z     (in_vec_z),
    .vec_w     (in_vec_w),
    .last      (in_last_in),
    .coeff     (coeff),
    .down_ready(s2_up_ready),
    .ctl       (s1_ctl),
    .prod      (s1_prod),
    .w_out     (s1_w)
  );

  qvr_accum_stage #(
    .VECTOR_WIDTH   (VECTOR_WIDTH),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (s1_ctl),
    .up_ready  (s2_up_ready),
    .prod      (s1_prod),
    .w_in      (s1_w),
    .down_ready(s3_up_ready),
    .ctl       (s2_ctl),
    .sum       (s2_sum),
    .w_out     (s2_w)
  );

  qvr_round_stage #(
    .VECTOR_WIDTH   (VECTOR_WIDTH),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (s2_ctl),
    .up_ready  (s3_up_ready),
    .sum       (s2_sum),
    .w_in      (s2_w),
    .down_ready(!out_stall),
    .ctl       (s3_ctl),
    .res       (s3_res),
    .w_out     (s3_w),
    .sat       (s3_sat)
  );

  assign out_valid     = s3_ctl.valid;
  assign out_x         = s3_res[0];
  assign out_y         = s3_res[1];
  assign out_z         = s3_res[2];
  assign out_w         = s3_w;
  assign out_last_out  = s3_ctl.last;
  assign out_saturated = s3_sat;

endmodule

/* hdl/qvr_coeff_unit.sv */
// ----------------------------------------------------------------------------
// qvr_coeff_unit
// Quaternion registers and the two-stage derivation of the nine rotation
// matrix coefficients (products, then sum / round / clip).
// ----------------------------------------------------------------------------
module qvr_coeff_unit
  import qvr_pkg::*;
#(
  parameter  int COEFF_FRAC_BITS = 14,
  localparam int CW              = COEFF_FRAC_BITS + 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  cfg_index_t                       cfg_index,
  input  logic [QUAT_WIDTH-1:0]            cfg_data,
  output logic [NUM_COEFFS-1:0][CW-1:0]    coeff,
  output logic                             busy
);

  localparam int SHIFT = RAW_FRAC_BITS - COEFF_FRAC_BITS;
  localparam int RND_W = RAW_WIDTH - SHIFT;

  localparam logic signed [RAW_WIDTH-1:0] RAW_ONE  = RAW_WIDTH'(1) <<< RAW_FRAC_BITS;
  localparam logic signed [RAW_WIDTH-1:0] RAW_HALF = RAW_WIDTH'(1) <<< (SHIFT - 1);
  localparam logic [CW-1:0] C_ONE  = CW'(1) << COEFF_FRAC_BITS;
  localparam logic [CW-1:0] C_ZERO = '0;
  localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [NUM_COEFFS-1:0][CW-1:0] COEFF_IDENT =
    {C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ONE};

  logic signed [QUAT_WIDTH-1:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [PROD_WIDTH-1:0] p_xx_r, p_yy_r, p_zz_r;
  logic signed [PROD_WIDTH-1:0] p_xy_r, p_xz_r, p_yz_r;
  logic signed [PROD_WIDTH-1:0] p_wx_r, p_wy_r, p_wz_r;
  logic signed [RAW_WIDTH-1:0]  raw [NUM_COEFFS];
  logic [NUM_COEFFS-1:0][CW-1:0] coeff_nxt;
  logic [NUM_COEFFS-1:0][CW-1:0] coeff_r;
  logic [1:0]                   busy_r;
  logic                         wr_en;

  // 2 * p widened to the raw Q.28 accumulator
  function automatic logic signed [RAW_WIDTH-1:0] dbl(input logic signed [PROD_WIDTH-1:0] p);
    return RAW_WIDTH'(p) <<< 1;
  endfunction

  assign cfg_ready = ~|busy_r;
  assign busy      = |busy_r;
  assign wr_en     = cfg_valid && cfg_ready;
  assign coeff     = coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= QUAT_ONE;
    end else if (wr_en) begin
      case (cfg_index)
        REG_QUAT_X: qx_r <= cfg_data;
        REG_QUAT_Y: qy_r <= cfg_data;
        REG_QUAT_Z: qz_r <= cfg_data;
        REG_QUAT_W: qw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy_r[0]: products being formed, busy_r[1]: coefficients being loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= {busy_r[0], wr_en};
    end
  end

  always_ff @(posedge clk) begin
    p_xx_r <= qx_r * qx_r;
    p_yy_r <= qy_r * qy_r;
    p_zz_r <= qz_r * qz_r;
    p_xy_r <= qx_r * qy_r;
    p_xz_r <= qx_r * qz_r;
    p_yz_r <= qy_r * qz_r;
    p_wx_r <= qw_r * qx_r;
    p_wy_r <= qw_r * qy_r;
    p_wz_r <= qw_r * qz_r;
  end

  always_comb begin
    raw[0] = RAW_ONE - dbl(p_yy_r) - dbl(p_zz_r);
    raw[1] = dbl(p_xy_r) - dbl(p_wz_r);
    raw[2] = dbl(p_xz_r) + dbl(p_wy_r);
    raw[3] = dbl(p_xy_r) + dbl(p_wz_r);
    raw[4] = RAW_ONE - dbl(p_xx_r) - dbl(p_zz_r);
    raw[5] = dbl(p_yz_r) - dbl(p_wx_r);
    raw[6] = dbl(p_xz_r) - dbl(p_wy_r);
    raw[7] = dbl(p_yz_r) + dbl(p_wx_r);
    raw[8] = RAW_ONE - dbl(p_xx_r) - dbl(p_yy_r);
  end

  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_round
    logic signed [RAW_WIDTH-1:0] biased;
    logic signed [RND_W-1:0]     rnd;
    logic                        ovf;

    assign biased = raw[k] + RAW_HALF;
    assign rnd    = RND_W'(biased >>> SHIFT);
    // out of range unless the bits above the coefficient sign all agree
    assign ovf    = !((&rnd[RND_W-1:CW-1]) || (~|rnd[RND_W-1:CW-1]));
    assign coeff_nxt[k] = ovf ? (rnd[RND_W-1] ? C_MIN : C_MAX) : rnd[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= COEFF_IDENT;
    end else if (busy_r[1]) begin
      coeff_r <= coeff_nxt;
    end
  end

  a_busy_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(busy_r))
    else $error("coefficient update overlapped a second write");

  a_coeff_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !busy_r[1] |=> $stable(coeff_r))
    else $error("coefficients changed outside an update");

endmodule

/* hdl/qvr_mult_stage.sv */
// ----------------------------------------------------------------------------
// qvr_mult_stage
// First pipeline stage: mode decode and the nine vector x coefficient
// products.
// ----------------------------------------------------------------------------
module qvr_mult_stage
  import qvr_pkg::*;
#(
  parameter  int VECTOR_WIDTH    = 32,
  parameter  int COEFF_FRAC_BITS = 14,
  localparam int CW              = COEFF_FRAC_BITS + 4,
  localparam int PW              = VECTOR_WIDTH + CW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  mode_t                              mode,
  input  logic [VECTOR_WIDTH-1:0]            vec_x,
  input  logic [VECTOR_WIDTH-1:0]            vec_y,
  input  logic [VECTOR_WIDTH-1:0]            vec_z,
  input  logic [VECTOR_WIDTH-1:0]            vec_w,
  input  logic                               last,
  input  logic [NUM_COEFFS-1:0][CW-1:0]      coeff,
  input  logic                               down_ready,
  output stage_ctl_t                         ctl,
  output logic [NUM_COEFFS-1:0][PW-1:0]      prod,
  output logic [VECTOR_WIDTH-1:0]            w_out
);

  localparam logic [VECTOR_WIDTH-1:0] VEC_ONE = VECTOR_WIDTH'(1) << (VECTOR_WIDTH / 2);

  logic [VECTOR_WIDTH-1:0]       z_sel, w_sel;
  logic signed [VECTOR_WIDTH-1:0] v [3];
  logic signed [PW-1:0]           prod_nxt [NUM_COEFFS];
  logic [NUM_COEFFS-1:0][PW-1:0]  prod_r;
  logic [VECTOR_WIDTH-1:0]        w_r;
  stage_ctl_t                     ctl_r;
  logic                           load;

  always_comb begin
    case (mode)
      MODE_FOUR: begin
        z_sel = vec_z;
        w_sel = vec_w;
      end
      MODE_THREE: begin
        z_sel = vec_z;
        w_sel = VEC_ONE;
      end
      MODE_TWO: begin
        z_sel = '0;
        w_sel = VEC_ONE;
      end
      default: begin
        // unused code behaves as three components
        z_sel = vec_z;
        w_sel = VEC_ONE;
      end
    endcase
  end

  assign v[0] = vec_x;
  assign v[1] = vec_y;
  assign v[2] = z_sel;

  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_mul
    assign prod_nxt[k] = v[k % 3] * $signed(coeff[k]);
  end

  assign up_ready = !ctl_r.valid || down_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (up_ready) begin
      ctl_r.valid <= up_valid;
    end
    if (load) begin
      for (int k = 0; k < NUM_COEFFS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      w_r        <= w_sel;
      ctl_r.last <= last;
    end
  end

  assign ctl   = ctl_r;
  assign prod  = prod_r;
  assign w_out = w_r;

endmodule

/* hdl/qvr_accum_stage.sv */
// ----------------------------------------------------------------------------
// qvr_accum_stage
// Second pipeline stage: three-term row sums plus the rounding half.
// ----------------------------------------------------------------------------
module qvr_accum_stage
  import qvr_pkg::*;
#(
  parameter  int VECTOR_WIDTH    = 32,
  parameter  int COEFF_FRAC_BITS = 14,
  localparam int CW              = COEFF_FRAC_BITS + 4,
  localparam int PW              = VECTOR_WIDTH + CW,
  localparam int SW              = PW + 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stage_ctl_t                         up_ctl,
  output logic                               up_ready,
  input  logic [NUM_COEFFS-1:0][PW-1:0]      prod,
  input  logic [VECTOR_WIDTH-1:0]            w_in,
  input  logic                               down_ready,
  output stage_ctl_t                         ctl,
  output logic [2:0][SW-1:0]                 sum,
  output logic [VECTOR_WIDTH-1:0]            w_out
);

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEFF_FRAC_BITS - 1);

  logic signed [SW-1:0]    sum_nxt [3];
  logic [2:0][SW-1:0]      sum_r;
  logic [VECTOR_WIDTH-1:0] w_r;
  stage_ctl_t              ctl_r;
  logic                    load;

  for (genvar r = 0; r < 3; r++) begin : g_row
    assign sum_nxt[r] = SW'($signed(prod[3*r])) + SW'($signed(prod[3*r+1]))
                      + SW'($signed(prod[3*r+2])) + HALF;
  end

  assign up_ready = !ctl_r.valid || down_ready;
  assign load     = up_ctl.valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (up_ready) begin
      ctl_r.valid <= up_ctl.valid;
    end
    if (load) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= sum_nxt[r];
      end
      w_r        <= w_in;
      ctl_r.last <= up_ctl.last;
    end
  end

  assign ctl   = ctl_r;
  assign sum   = sum_r;
  assign w_out = w_r;

endmodule

/* hdl/qvr_round_stage.sv */
// ----------------------------------------------------------------------------
// qvr_round_stage
// Last pipeline stage: drop the coefficient fraction bits, saturate each
// component and hold the result item for the output channel.
// ----------------------------------------------------------------------------
module qvr_round_stage
  import qvr_pkg::*;
#(
  parameter  int VECTOR_WIDTH    = 32,
  parameter  int COEFF_FRAC_BITS = 14,
  localparam int CW              = COEFF_FRAC_BITS + 4,
  localparam int SW              = VECTOR_WIDTH + CW + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stage_ctl_t                  up_ctl,
  output logic                        up_ready,
  input  logic [2:0][SW-1:0]          sum,
  input  logic [VECTOR_WIDTH-1:0]     w_in,
  input  logic                        down_ready,
  output stage_ctl_t                  ctl,
  output logic [2:0][VECTOR_WIDTH-1:0] res,
  output logic [VECTOR_WIDTH-1:0]     w_out,
  output logic                        sat
);

  localparam int SHW = SW - COEFF_FRAC_BITS;
  localparam logic [VECTOR_WIDTH-1:0] V_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
  localparam logic [VECTOR_WIDTH-1:0] V_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

  logic [2:0][VECTOR_WIDTH-1:0] res_nxt, res_r;
  logic [2:0]                   clip;
  logic [VECTOR_WIDTH-1:0]      w_r;
  logic                         sat_r;
  stage_ctl_t                   ctl_r;
  logic                         load;

  for (genvar r = 0; r < 3; r++) begin : g_sat
    logic signed [SHW-1:0] shifted;

    // floor shift; the half was added upstream
    assign shifted    = SHW'($signed(sum[r]) >>> COEFF_FRAC_BITS);
    assign clip[r]    = !((&shifted[SHW-1:VECTOR_WIDTH-1]) ||
                          (~|shifted[SHW-1:VECTOR_WIDTH-1]));
    assign res_nxt[r] = clip[r] ? (shifted[SHW-1] ? V_MIN : V_MAX)
                                : shifted[VECTOR_WIDTH-1:0];
  end

  assign up_ready = !ctl_r.valid || down_ready;
  assign load     = up_ctl.valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (up_ready) begin
      ctl_r.valid <= up_ctl.valid;
    end
    if (load) begin
      res_r      <= res_nxt;
      w_r        <= w_in;
      sat_r      <= |clip;
      ctl_r.last <= up_ctl.last;
    end
  end

  assign ctl   = ctl_r;
  assign res   = res_r;
  assign w_out = w_r;
  assign sat   = sat_r;

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.valid && sat_r |->
      (res_r[0] == V_MAX) || (res_r[0] == V_MIN) ||
      (res_r[1] == V_MAX) || (res_r[1] == V_MIN) ||
      (res_r[2] == V_MAX) || (res_r[2] == V_MIN))
    else $error("saturation flagged but no component at a range limit");

endmodule

/* verif/quaternion_vector_rotator_core_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotator_core_tb
// Streams directed and random vectors through the rotator under a range of
// quaternion settings, including out-of-range ones that clip the rotation
// coefficients. A fixed-point predictor computes each rotated vector and a
// scoreboard compares every result field by field, in order.
// ----------------------------------------------------------------------------
module quaternion_vector_rotator_core_tb;
  import qvr_pkg::*;

  localparam int VW              = 32;
  localparam int CF              = 14;
  localparam int CW              = CF + 4;
  localparam int PIPE_LATENCY    = 3;
  localparam int HOLD_CYCLES     = 64;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 106;

  localparam mode_t MODE_SPARE = 2'd3;  // unused code, behaves as three components

  localparam logic signed [VW-1:0] VEC_ONE = VW'(1) << (VW / 2);
  localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    mode_t                mode;
    logic signed [VW-1:0] x, y, z, w;
    logic                 last;
  } vec_item_t;

  typedef struct {
    logic signed [VW-1:0] x, y, z, w;
    logic                 last;
    logic                 sat;
  } rot_result_t;

  class rotation_checker;
    logic signed [QUAT_WIDTH-1:0] quat [4];
    longint                       coeff [NUM_COEFFS];
    rot_result_t                  pending [$];
    int                           errors;
    int                           checked;

    function new();
      quat[REG_QUAT_X] = '0;
      quat[REG_QUAT_Y] = '0;
      quat[REG_QUAT_Z] = '0;
      quat[REG_QUAT_W] = QUAT_ONE;
      errors  = 0;
      checked = 0;
      derive_coeffs();
    endfunction

    function longint clip(longint v, int width, inout bit flag);
      longint hi_lim, lo_lim;
      hi_lim = (longint'(1) <<< (width - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) begin
        flag = 1'b1;
        return hi_lim;
      end
      if (v < lo_lim) begin
        flag = 1'b1;
        return lo_lim;
      end
      return v;
    endfunction

    // exact products carry 28 fraction bits; round half up to CF bits
    function void derive_coeffs();
      longint x, y, z, w, one, half;
      longint raw [NUM_COEFFS];
      bit     unused;
      x    = longint'(quat[REG_QUAT_X]);
      y    = longint'(quat[REG_QUAT_Y]);
      z    = longint'(quat[REG_QUAT_Z]);
      w    = longint'(quat[REG_QUAT_W]);
      one  = longint'(1) <<< RAW_FRAC_BITS;
      half = longint'(1) <<< (RAW_FRAC_BITS - CF - 1);
      raw[0] = one - 2 * y * y - 2 * z * z;
      raw[1] = 2 * x * y - 2 * w * z;
      raw[2] = 2 * x * z + 2 * w * y;
      raw[3] = 2 * x * y + 2 * w * z;
      raw[4] = one - 2 * x * x - 2 * z * z;
      raw[5] = 2 * y * z - 2 * w * x;
      raw[6] = 2 * x * z - 2 * w * y;
      raw[7] = 2 * y * z + 2 * w * x;
      raw[8] = one - 2 * x * x - 2 * y * y;
      foreach (coeff[i])
        coeff[i] = clip((raw[i] + half) >>> (RAW_FRAC_BITS - CF), CW, unused);
    endfunction

    function void write_reg(cfg_index_t idx, logic [QUAT_WIDTH-1:0] data);
      if (idx > REG_QUAT_W) return;  // unmapped index, no effect
      quat[idx] = data;
      derive_coeffs();
    endfunction

    function void note_input(vec_item_t it);
      longint      v [3];
      longint      rows [3];
      longint      sum;
      rot_result_t r;
      bit          sat;
      v[0] = longint'(it.x);
      v[1] = longint'(it.y);
      v[2] = (it.mode == MODE_TWO) ? longint'(0) : longint'(it.z);
      sat  = 1'b0;
      for (int row = 0; row < 3; row++) begin
        sum = coeff[3*row] * v[0] + coeff[3*row+1] * v[1] + coeff[3*row+2] * v[2];
        rows[row] = clip((sum + (longint'(1) <<< (CF - 1))) >>> CF, VW, sat);
      end
      r.x    = VW'(rows[0]);
      r.y    = VW'(rows[1]);
      r.z    = VW'(rows[2]);
      r.w    = (it.mode == MODE_FOUR) ? it.w : VEC_ONE;
      r.last = it.last;
      r.sat  = sat;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("error: result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(rot_result_t got);
      rot_result_t want;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report($sformatf("out_x %h, want %h", got.x, want.x));
      if (got.y !== want.y) report($sformatf("out_y %h, want %h", got.y, want.y));
      if (got.z !== want.z) report($sformatf("out_z %h, want %h", got.z, want.z));
      if (got.w !== want.w) report($sformatf("out_w %h, want %h", got.w, want.w));
      if (got.last !== want.last)
        report($sformatf("out_last_out %b, want %b", got.last, want.last));
      if (got.sat !== want.sat)
        report($sformatf("out_saturated %b, want %b", got.sat, want.sat));
      checked++;
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     in_mode;
  logic signed [VW-1:0]           in_vec_x, in_vec_y, in_vec_z, in_vec_w;
  logic                           in_last_in;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [VW-1:0]           out_x, out_y, out_z, out_w;
  logic                           out_last_out;
  logic                           out_saturated;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]     cfg_index;
  logic [QUAT_WIDTH-1:0]          cfg_data;

  rotation_checker sb = new();
  bit              quiet;         // no random idling on either side
  bit              hold_request;  // asks the receiver for one long stall
  int              cycles;

  quaternion_vector_rotator_core #(
    .VECTOR_WIDTH    (VW),
    .COEFF_FRAC_BITS (CF)
  ) uut (.*);

  always #10 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side: check accepted items, then pick the next stall value
  initial begin
    int          stall_left;
    rot_result_t got;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.x    = out_x;
        got.y    = out_y;
        got.z    = out_z;
        got.w    = out_w;
        got.last = out_last_out;
        got.sat  = out_saturated;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [VW-1:0] random_comp();
    case ($urandom_range(0, 3))
      0:       return VW'($urandom);
      1:       return VW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2:       return VW'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
      default: return $urandom_range(0, 1) ? VEC_MAX : VEC_MIN;
    endcase
  endfunction

  function automatic vec_item_t random_item();
    vec_item_t it;
    it.mode = mode_t'($urandom_range(0, 3));
    it.x    = random_comp();
    it.y    = random_comp();
    it.z    = random_comp();
    it.w    = random_comp();
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic send_item(vec_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= it.mode;
    in_vec_x   <= it.x;
    in_vec_y   <= it.y;
    in_vec_z   <= it.z;
    in_vec_w   <= it.w;
    in_last_in <= it.last;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // writes the masked quaternion registers, then optionally an unmapped index
  task automatic load_rotation(input logic [QUAT_WIDTH-1:0] q [4], input logic [3:0] mask,
                               input bit junk);
    cfg_index_t            idx;
    logic [QUAT_WIDTH-1:0] data;
    for (int k = 0; k <= 4; k++) begin
      if (k < 4) begin
        if (!mask[k]) continue;
        idx  = cfg_index_t'(k);
        data = q[k];
      end else begin
        if (!junk) continue;
        idx  = cfg_index_t'($urandom_range(int'(REG_QUAT_W) + 1,
                                           (1 << CFG_INDEX_WIDTH) - 1));
        data = QUAT_WIDTH'($urandom);
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed();
    send_item(vec_item_t'{MODE_FOUR, '0, '0, '0, '0, 1'b0});
    send_item(vec_item_t'{MODE_FOUR, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, 1'b1});
    send_item(vec_item_t'{MODE_FOUR, VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN, 1'b0});
    send_item(vec_item_t'{MODE_THREE, VEC_MAX, VEC_MIN, VEC_MAX, 32'sh1234_5678, 1'b1});
    // two components: z must be ignored
    send_item(vec_item_t'{MODE_TWO, 32'sh0001_8000, -32'sd1, VEC_MAX, VEC_MIN, 1'b0});
    send_item(vec_item_t'{MODE_SPARE, 32'sh0002_0000, VEC_MIN, 32'sh0000_8000, VEC_MAX, 1'b1});
    send_item(vec_item_t'{MODE_FOUR, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1});
    send_item(vec_item_t'{MODE_THREE, 32'sd1, 32'sh0000_2000, -32'sd2, '0, 1'b0});
    send_item(vec_item_t'{MODE_TWO, VEC_MIN, VEC_MAX, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1});
    send_item(vec_item_t'{MODE_FOUR, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                          32'shF0F0_F0F0, 1'b0});
  endtask

  initial begin
    logic [QUAT_WIDTH-1:0] q [4];
    logic [3:0]            mask;
    bit                    junk;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_FOUR;
    in_vec_x   <= '0;
    in_vec_y   <= '0;
    in_vec_z   <= '0;
    in_vec_w   <= '0;
    in_last_in <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_QUAT_X;
    cfg_data   <= '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph >= NUM_PHASES - 2);
      mask  = 4'hF;
      junk  = 1'b0;
      case (ph)
        0: mask = 4'h0;  // identity from reset
        1: begin
          q    = '{16'h4000, 16'hC000, 16'h4000, 16'hC000};
          junk = 1'b1;
        end
        2: q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};  // coefficients clip
        3: q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        4: q = '{16'h0000, 16'h0000, 16'h2D41, 16'h2D41};  // quarter turn about z
        default: begin
          foreach (q[k]) begin
            if (ph % 3 == 1) q[k] = QUAT_WIDTH'($urandom);
            else q[k] = QUAT_WIDTH'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
          end
          if (ph % 3 == 1) mask = 4'($urandom_range(1, 15));
          if (ph % 3 == 2) begin
            mask = 4'h1 << $urandom_range(0, 3);
            junk = 1'b1;
          end
        end
      endcase
      if (mask != 4'h0 || junk) load_rotation(q, mask, junk);
      if (ph == 0 || ph == 2) send_directed();
      if (ph == 5) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 7 && n == ITEMS_PER_PHASE / 2) drain();
        send_item(random_item());
      end
      drain();
    end

    repeat (PIPE_LATENCY + 1) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
